// ===== src/uhsf_pkg.sv =====
// Shared types and constants for the unique hash stream filter.
// No dependencies; used by the channel interfaces and every module.
`timescale 1ns / 1ps

package uhsf_pkg;

  localparam int unsigned LOW_W  = 64;
  localparam int unsigned MID_W  = 64;
  localparam int unsigned HIGH_W = 32;
  localparam int unsigned FULL_W = LOW_W + MID_W + HIGH_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_EMIT
  } uhsf_state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } uhsf_mem_ctl_t;

  typedef struct packed {
    logic idle;
    logic full;
    logic emit;
  } uhsf_status_t;

endpackage

// ===== src/uhsf_if.sv =====
// Valid/ready channel interfaces for the hash filter input and result beats.
// Depends on uhsf_pkg for field widths.
`timescale 1ns / 1ps

interface uhsf_in_if;
  logic                         valid;
  logic                         ready;
  logic [uhsf_pkg::LOW_W-1:0]   hash_low;
  logic [uhsf_pkg::MID_W-1:0]   hash_mid;
  logic [uhsf_pkg::HIGH_W-1:0]  hash_high;
  logic                         exists_locally;

  modport source (output valid, hash_low, hash_mid, hash_high, exists_locally,
                  input ready);
  modport sink   (input valid, hash_low, hash_mid, hash_high, exists_locally,
                  output ready);
endinterface

interface uhsf_out_if;
  logic                         valid;
  logic                         ready;
  logic [uhsf_pkg::LOW_W-1:0]   out_hash_low;
  logic [uhsf_pkg::MID_W-1:0]   out_hash_mid;
  logic [uhsf_pkg::HIGH_W-1:0]  out_hash_high;
  logic                         out_exists_locally;
  logic                         not_recorded;

  modport source (output valid, out_hash_low, out_hash_mid, out_hash_high,
                  out_exists_locally, not_recorded, input ready);
  modport sink   (input valid, out_hash_low, out_hash_mid, out_hash_high,
                  out_exists_locally, not_recorded, output ready);
endinterface

// ===== src/uhsf_table.sv =====
// Seen-hash table: single-port-write, registered-read synchronous memory.
// Depends on uhsf_pkg for the memory control struct.
`timescale 1ns / 1ps

module uhsf_table #(
  parameter int unsigned ENTRIES = 256,
  parameter int unsigned IDX_W   = 8,
  parameter int unsigned DATA_W  = 160
) (
  input  logic                    clk,
  input  uhsf_pkg::uhsf_mem_ctl_t ctl,
  input  logic [IDX_W-1:0]        rd_addr,
  output logic [DATA_W-1:0]       rd_data,
  input  logic [IDX_W-1:0]        wr_addr,
  input  logic [DATA_W-1:0]       wr_data
);

  logic [DATA_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/uhsf_search.sv =====
// Search sequencer: walks the seen table one entry a cycle, appends new hashes while room remains.
// Depends on uhsf_pkg (state enum, memory control and status structs).
`timescale 1ns / 1ps

module uhsf_search #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned KEY_W         = 160,
  parameter int unsigned IDX_W         = 8,
  parameter int unsigned CNT_W         = 9
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [KEY_W-1:0]        in_key,
  input  logic                    in_flag,
  input  logic                    slot_free,
  input  logic [KEY_W-1:0]        rd_data,
  output uhsf_pkg::uhsf_mem_ctl_t mem_ctl,
  output logic [IDX_W-1:0]        rd_addr,
  output logic [IDX_W-1:0]        wr_addr,
  output logic [KEY_W-1:0]        key,
  output logic                    flag,
  output uhsf_pkg::uhsf_status_t  status
);

  uhsf_pkg::uhsf_state_t state_r, state_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic                  flag_r, flag_nxt;
  logic                  full;
  logic                  emit;

  assign full    = (count_r == CNT_W'(TABLE_ENTRIES));
  assign rd_addr = (state_r == uhsf_pkg::S_IDLE) ? '0 : idx_r[IDX_W-1:0];
  assign wr_addr = count_r[IDX_W-1:0];
  assign key     = key_r;
  assign flag    = flag_r;
  assign status  = '{idle: (state_r == uhsf_pkg::S_IDLE), full: full, emit: emit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= uhsf_pkg::S_IDLE;
      idx_r   <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    flag_r <= flag_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    key_nxt   = key_r;
    flag_nxt  = flag_r;
    in_ready  = 1'b0;
    mem_ctl   = '0;
    emit      = 1'b0;
    case (state_r)
      uhsf_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          key_nxt  = in_key;
          flag_nxt = in_flag;
          if (count_r == '0) begin
            state_nxt = uhsf_pkg::S_EMIT;
          end else begin
            mem_ctl.rd_en = 1'b1;
            idx_nxt       = CNT_W'(1);
            state_nxt     = uhsf_pkg::S_SEARCH;
          end
        end
      end
      uhsf_pkg::S_SEARCH: begin
        // rd_data holds entry idx_r-1
        if (rd_data == key_r) begin
          state_nxt = uhsf_pkg::S_IDLE;
        end else if (idx_r == count_r) begin
          state_nxt = uhsf_pkg::S_EMIT;
        end else begin
          mem_ctl.rd_en = 1'b1;
          idx_nxt       = idx_r + CNT_W'(1);
        end
      end
      uhsf_pkg::S_EMIT: begin
        if (slot_free) begin
          emit = 1'b1;
          if (!full) begin
            mem_ctl.wr_en = 1'b1;
            count_nxt     = count_r + CNT_W'(1);
          end
          state_nxt = uhsf_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = uhsf_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/unique_hash_stream_filter_core.sv =====
// Top level of the unique hash stream filter: search sequencer, seen table
// and result register. Depends on uhsf_pkg, uhsf_if, uhsf_search, uhsf_table.
//
// Usage: input beats arrive on in_ch (valid/ready) carrying a hash of up to
// 20 bytes in three fields plus an exists-locally flag. Bytes at and above
// HASH_BYTES are ignored for matching and read back as zero. A hash already
// in the seen table is dropped with no result beat. A new hash is appended
// and sent on out_ch with its flag; once TABLE_ENTRIES hashes are stored a
// new hash is still sent but not stored, with not_recorded set.
// Timing: one item at a time. The search scans the table read port one
// entry per cycle; a duplicate frees the input as soon as the matching
// entry is read.
// Reset: synchronous, active low; the table is empty afterwards, no clearing
// pass is needed. A stalled receiver holds the result register; the next
// item is accepted and searched meanwhile, and waits only to hand over its
// own result.
`timescale 1ns / 1ps

module unique_hash_stream_filter_core #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned HASH_BYTES    = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  uhsf_in_if.sink     in_ch,
  uhsf_out_if.source  out_ch
);

  localparam int unsigned FULL_W = uhsf_pkg::FULL_W;
  localparam int unsigned KEY_W  = HASH_BYTES * 8;
  localparam int unsigned IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_ENTRIES + 1);

  logic [FULL_W-1:0]       in_full;
  logic [KEY_W-1:0]        in_key;
  logic [KEY_W-1:0]        rd_data;
  logic [KEY_W-1:0]        key;
  logic                    flag;
  logic [IDX_W-1:0]        rd_addr;
  logic [IDX_W-1:0]        wr_addr;
  logic                    slot_free;
  uhsf_pkg::uhsf_mem_ctl_t mem_ctl;
  uhsf_pkg::uhsf_status_t  status;

  logic                    out_valid_r, out_valid_nxt;
  logic [FULL_W-1:0]       out_hash_r;
  logic                    out_flag_r;
  logic                    out_nrec_r;

  assign in_full = {in_ch.hash_high, in_ch.hash_mid, in_ch.hash_low};
  assign in_key  = in_full[KEY_W-1:0];

  uhsf_search #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_W         (KEY_W),
    .IDX_W         (IDX_W),
    .CNT_W         (CNT_W)
  ) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_key    (in_key),
    .in_flag   (in_ch.exists_locally),
    .slot_free (slot_free),
    .rd_data   (rd_data),
    .mem_ctl   (mem_ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .key       (key),
    .flag      (flag),
    .status    (status)
  );

  uhsf_table #(
    .ENTRIES (TABLE_ENTRIES),
    .IDX_W   (IDX_W),
    .DATA_W  (KEY_W)
  ) u_table (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_addr (wr_addr),
    .wr_data (key)
  );

  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (status.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (status.emit) begin
      out_hash_r <= FULL_W'(key);
      out_flag_r <= flag;
      out_nrec_r <= status.full;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.out_hash_low       = out_hash_r[uhsf_pkg::LOW_W-1:0];
  assign out_ch.out_hash_mid       = out_hash_r[uhsf_pkg::LOW_W +: uhsf_pkg::MID_W];
  assign out_ch.out_hash_high      = out_hash_r[FULL_W-1 -: uhsf_pkg::HIGH_W];
  assign out_ch.out_exists_locally = out_flag_r;
  assign out_ch.not_recorded       = out_nrec_r;

  // sequencer is not ready in the cycle after taking a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while search still busy");

  // a result is only loaded when the output register can take it
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    status.emit |-> (!out_valid_r || out_ch.ready))
    else $error("pending result overwritten");

  // the table never empties, so an unrecorded result implies a full table
  a_nrec_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.not_recorded) |-> status.full)
    else $error("not_recorded set with table not full");

  // new results are loaded only on the way back to idle
  a_emit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    status.emit |=> status.idle)
    else $error("sequencer did not return to idle after result");

endmodule

// ===== verif/unique_hash_stream_filter_core_tb.sv =====
// Self-checking bench for unique_hash_stream_filter_core: a directed and
// random stream of hashes with duplicates, near misses and a full table.
// Depends on uhsf_pkg, uhsf_if and the core RTL.
`timescale 1ns / 1ps

module unique_hash_stream_filter_core_tb;

  localparam int unsigned LOW_W       = uhsf_pkg::LOW_W;
  localparam int unsigned MID_W       = uhsf_pkg::MID_W;
  localparam int unsigned HIGH_W      = uhsf_pkg::HIGH_W;
  localparam int unsigned FULL_W      = uhsf_pkg::FULL_W;

  localparam int unsigned TE          = 256;
  localparam int unsigned HB          = 20;
  localparam int unsigned N_RAND      = 1580;
  localparam int unsigned STALL_LIMIT = 20 * (TE + 2) + 1000;

  typedef struct packed {
    logic [HIGH_W-1:0] high;
    logic [MID_W-1:0]  mid;
    logic [LOW_W-1:0]  low;
    logic              flag;
  } hash_beat_t;

  typedef struct packed {
    logic [HIGH_W-1:0] high;
    logic [MID_W-1:0]  mid;
    logic [LOW_W-1:0]  low;
    logic              flag;
    logic              not_rec;
  } fwd_beat_t;

  logic clk;
  logic rst_n;

  uhsf_in_if  in_ch ();
  uhsf_out_if out_ch ();

  unique_hash_stream_filter_core #(
    .TABLE_ENTRIES(TE),
    .HASH_BYTES   (HB)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  hash_beat_t        stim_q[$];
  fwd_beat_t         forwarded_q[$];
  logic [FULL_W-1:0] sent_hashes[$];
  logic [FULL_W-1:0] seen_tab[TE];
  int unsigned       seen_n = 0;
  int unsigned       n_items = 0;
  int unsigned       accepted_in = 0;
  int                fails = 0;

  function automatic logic [FULL_W-1:0] kept_mask();
    logic [FULL_W-1:0] m;
    m = '0;
    for (int b = 0; b < HB; b++) m[8*b +: 8] = 8'hFF;
    return m;
  endfunction

  function automatic logic [FULL_W-1:0] rand_hash();
    return {$urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic void add_item(logic [FULL_W-1:0] h, logic flag);
    hash_beat_t b;
    b.low  = h[LOW_W-1:0];
    b.mid  = h[LOW_W +: MID_W];
    b.high = h[LOW_W+MID_W +: HIGH_W];
    b.flag = flag;
    stim_q.insert(stim_q.size(), b);
    sent_hashes.insert(sent_hashes.size(), h);
  endfunction

  // seen-set filter: drop on match, else forward and store while room remains
  function automatic void filter_predict(hash_beat_t b);
    logic [FULL_W-1:0] h;
    fwd_beat_t         r;
    h = {b.high, b.mid, b.low} & kept_mask();
    for (int i = 0; i < int'(seen_n); i++) begin
      if (seen_tab[i] == h) return;
    end
    r.low     = h[LOW_W-1:0];
    r.mid     = h[LOW_W +: MID_W];
    r.high    = h[LOW_W+MID_W +: HIGH_W];
    r.flag    = b.flag;
    r.not_rec = (seen_n >= TE);
    if (seen_n < TE) begin
      seen_tab[seen_n] = h;
      seen_n++;
    end
    forwarded_q.insert(forwarded_q.size(), r);
  endfunction

  function automatic int unsigned phase_of();
    if (accepted_in < n_items / 3) return 0;
    if (accepted_in < 2 * n_items / 3) return 1;
    return 2;
  endfunction

  function automatic int unsigned send_idle_pct();
    case (phase_of())
      0: return 9;
      1: return 62;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned recv_idle_pct();
    case (phase_of())
      0: return 62;
      1: return 9;
      default: return 0;
    endcase
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fails++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n                    = 1'b0;
    in_ch.valid              = 1'b0;
    in_ch.hash_low           = '0;
    in_ch.hash_mid           = '0;
    in_ch.hash_high          = '0;
    in_ch.exists_locally     = 1'b0;
    out_ch.ready             = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin : stim_gen
    logic [FULL_W-1:0] h;
    int unsigned       r;
    add_item('0, 1'b0);
    add_item('0, 1'b0);
    add_item('0, 1'b1);
    add_item('1, 1'b1);
    add_item(~kept_mask(), 1'b0);
    add_item(kept_mask(), 1'b0);
    add_item({5{32'h5555_5555}}, 1'b1);
    add_item({5{32'hAAAA_AAAA}}, 1'b0);
    add_item({5{32'h5555_5555}} ^ ~kept_mask(), 1'b0);
    add_item(160'b1, 1'b0);
    add_item(160'b1 << 63, 1'b1);
    add_item(160'b1 << 64, 1'b0);
    add_item(160'b1 << 127, 1'b1);
    add_item(160'b1 << 128, 1'b0);
    add_item(160'b1 << (8 * HB - 1), 1'b1);
    add_item(160'b1 << (8 * HB), 1'b1);
    add_item(160'b1 << 159, 1'b0);
    add_item(kept_mask() ^ (160'b1 << 77), 1'b1);
    add_item(160'b1 << 63, 1'b0);
    for (int k = 0; k < int'(N_RAND); k++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        h = rand_hash();
      end else if (r < 65) begin
        h = sent_hashes[$urandom_range(0, sent_hashes.size() - 1)];
        h = (h & kept_mask()) | (rand_hash() & ~kept_mask());
      end else if (r < 80) begin
        h = sent_hashes[$urandom_range(0, sent_hashes.size() - 1)];
        h[$urandom_range(0, FULL_W - 1)] ^= 1'b1;
      end else begin
        h = (FULL_W'($urandom_range(0, 15))) | (rand_hash() & ~kept_mask());
      end
      add_item(h, 1'($urandom_range(0, 1)));
    end
    n_items = stim_q.size();

    while (rst_n !== 1'b1) @(posedge clk);
    while (stim_q.size() != 0 || in_ch.valid || forwarded_q.size() != 0) @(posedge clk);
    repeat (TE + 8) @(posedge clk);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  always @(posedge clk) begin : drive_in
    hash_beat_t cur;
    hash_beat_t nb;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        cur.low  = in_ch.hash_low;
        cur.mid  = in_ch.hash_mid;
        cur.high = in_ch.hash_high;
        cur.flag = in_ch.exists_locally;
        filter_predict(cur);
        accepted_in <= accepted_in + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (stim_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          nb = stim_q.pop_front();
          in_ch.valid          <= 1'b1;
          in_ch.hash_low       <= nb.low;
          in_ch.hash_mid       <= nb.mid;
          in_ch.hash_high      <= nb.high;
          in_ch.exists_locally <= nb.flag;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_out
    fwd_beat_t exp_b;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct());
      if (out_ch.valid && out_ch.ready) begin
        if (forwarded_q.size() == 0) begin
          $error("result beat with nothing expected: hash %h_%h_%h",
                 out_ch.out_hash_high, out_ch.out_hash_mid, out_ch.out_hash_low);
          fails++;
        end else begin
          exp_b = forwarded_q.pop_front();
          check_field("out_hash_low", exp_b.low, out_ch.out_hash_low);
          check_field("out_hash_mid", exp_b.mid, out_ch.out_hash_mid);
          check_field("out_hash_high", 64'(exp_b.high), 64'(out_ch.out_hash_high));
          check_field("out_exists_locally", 64'(exp_b.flag), 64'(out_ch.out_exists_locally));
          check_field("not_recorded", 64'(exp_b.not_rec), 64'(out_ch.not_recorded));
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/uhsf_pkg.sv
src/uhsf_if.sv
src/uhsf_table.sv
src/uhsf_search.sv
src/unique_hash_stream_filter_core.sv
verif/unique_hash_stream_filter_core_tb.sv
